[sv/hvc_pkg.sv]
// types and constants shared by the handpoint velocity converter
// no dependencies
package hvc_pkg;

    localparam int MaxSteps = 24;
    localparam logic signed [35:0] AngPi     = 36'sd1686629713;
    localparam logic signed [35:0] AngHalfPi = 36'sd843314856;
    localparam logic signed [35:0] CordicGain = 36'sd652032874;
    localparam logic signed [15:0] HeadingMax = 16'sd25736;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_SOURCE = 2'd1;
    localparam logic [1:0] REG_INDEX  = 2'd2;

    localparam logic [1:0] SRC_SIM = 2'd1;
    localparam logic [1:0] SRC_MOCAP = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE, OP_QUAT, OP_VEC, OP_ROT, OP_POSE, OP_VEL, OP_DIV, OP_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

    function automatic logic signed [35:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0: atan_entry = 36'sd421657428;
            5'd1: atan_entry = 36'sd248918915;
            5'd2: atan_entry = 36'sd131521918;
            5'd3: atan_entry = 36'sd66762579;
            5'd4: atan_entry = 36'sd33510843;
            5'd5: atan_entry = 36'sd16771758;
            5'd6: atan_entry = 36'sd8387925;
            5'd7: atan_entry = 36'sd4194219;
            5'd8: atan_entry = 36'sd2097141;
            5'd9: atan_entry = 36'sd1048575;
            5'd10: atan_entry = 36'sd524288;
            5'd11: atan_entry = 36'sd262144;
            5'd12: atan_entry = 36'sd131072;
            5'd13: atan_entry = 36'sd65536;
            5'd14: atan_entry = 36'sd32768;
            5'd15: atan_entry = 36'sd16384;
            5'd16: atan_entry = 36'sd8192;
            5'd17: atan_entry = 36'sd4096;
            5'd18: atan_entry = 36'sd2048;
            5'd19: atan_entry = 36'sd1024;
            5'd20: atan_entry = 36'sd512;
            5'd21: atan_entry = 36'sd256;
            5'd22: atan_entry = 36'sd128;
            5'd23: atan_entry = 36'sd64;
            default: atan_entry = 36'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

[sv/hvc_ctrl.sv]
// controller sequencing the datapath for one transaction
// depends on hvc_pkg
module hvc_ctrl import hvc_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_cmd,
    input  logic    i_rot_needed,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_load_out,
    output logic    o_kind
);

    localparam int CW = $clog2(MaxSteps + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_QUAT, S_VEC, S_ROT_P, S_ROT, S_POSE, S_VEL, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt;
    logic r_kind;

    always_comb begin
        o_cmd = '{op: OP_NONE};
        case (r_state)
            S_QUAT:  o_cmd.op = OP_QUAT;
            S_VEC:   o_cmd.op = OP_VEC;
            S_ROT_P: o_cmd.op = OP_LOAD;
            S_ROT:   o_cmd.op = OP_ROT;
            S_POSE:  o_cmd.op = OP_POSE;
            S_VEL:   o_cmd.op = OP_VEL;
            S_DIV:   o_cmd.op = OP_DIV;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_load_out = (r_state == S_OUT);
    assign o_kind = r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_kind <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_kind <= i_cmd;
                    r_state <= i_cmd ? S_ROT_P : S_QUAT;
                end
                S_QUAT: begin r_cnt <= '0; r_state <= S_VEC; end
                S_VEC: begin
                    if (r_cnt == CW'(STEPS - 1)) begin
                        r_state <= i_rot_needed ? S_ROT_P : S_OUT;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_ROT_P: begin r_cnt <= '0; r_state <= S_ROT; end
                S_ROT: begin
                    if (r_cnt == CW'(STEPS - 1))
                        r_state <= r_kind ? S_VEL : S_POSE;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_POSE: r_state <= S_OUT;
                S_VEL:  r_state <= S_DIV;
                S_DIV:  if (i_status.done) r_state <= S_OUT;
                S_OUT:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/hvc_dp.sv]
// datapath: shared cordic, multipliers, restoring divider, pose state
// depends on hvc_pkg
module hvc_dp import hvc_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_capture,
    input  logic signed [15:0] i_qx,
    input  logic signed [15:0] i_qy,
    input  logic signed [15:0] i_qz,
    input  logic signed [15:0] i_qw,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_vx,
    input  logic signed [31:0] i_vy,
    input  logic [20:0]        i_offset,
    input  logic [1:0]         i_source,
    input  logic [3:0]         i_index,
    output t_status            o_status,
    output logic               o_rot_needed,
    output logic signed [31:0] o_lin,
    output logic signed [31:0] o_turn,
    output logic signed [15:0] o_heading,
    output logic signed [31:0] o_hx,
    output logic signed [31:0] o_hy
);

    localparam int CW = $clog2(MaxSteps + 1);

    // captured item
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    // cordic registers
    logic signed [35:0] r_x, r_y, r_z;
    logic [CW-1:0] r_i;
    logic r_flip;
    // results and state
    logic signed [15:0] r_heading;
    logic signed [31:0] r_hx, r_hy, r_lin;
    // divider
    logic [64:0] r_rem;
    logic [64:0] r_mag;
    logic [6:0] r_dcnt;
    logic r_neg;
    logic [64:0] r_quo;
    logic signed [31:0] r_turn;
    logic signed [65:0] r_vn, r_wn;

    logic signed [35:0] xs, ys, ang;
    logic signed [33:0] num, den;
    logic signed [35:0] zr;
    logic signed [35:0] zn;
    logic signed [15:0] h_raw;
    logic signed [36:0] h_full;
    logic signed [35:0] cosv, sinv;
    logic signed [32:0] py_adj;
    logic signed [65:0] off_c, off_s;
    logic [64:0] d_val, rem_sh;
    logic [4:0] ai;

    assign ai = 5'(r_i);
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign ang = atan_entry(ai);
    assign num = 34'(2 * (34'(r_qw) * 34'(r_qz) + 34'(r_qx) * 34'(r_qy)));
    assign den = 34'sd268435456 - 34'(2 * (34'(r_qy) * 34'(r_qy) + 34'(r_qz) * 34'(r_qz)));
    assign zr = 36'(r_heading) * 36'sd65536;
    // angle after the current vectoring step, rounded to the heading format
    assign zn = (r_y > 0) ? r_z + ang : r_z - ang;
    assign h_full = (37'(zn) + 37'sd32768) >>> 16;
    assign h_raw = (h_full > 37'(HeadingMax)) ? HeadingMax :
                   (h_full < -37'(HeadingMax)) ? -HeadingMax : 16'(h_full);
    assign cosv = r_flip ? -r_x : r_x;
    assign sinv = r_flip ? -r_y : r_y;
    assign py_adj = (i_source == SRC_SIM) ? 33'(r_py) :
                    33'(r_py) - (33'($signed({1'b0, i_index})) - 33'sd2) * 33'sd65536;
    assign off_c = 66'($signed({1'b0, i_offset})) * 66'(cosv);
    assign off_s = 66'($signed({1'b0, i_offset})) * 66'(sinv);
    assign d_val = 65'(i_offset) << 14;
    assign rem_sh = {r_rem[63:0], r_mag[64]};

    assign o_rot_needed = (i_source != SRC_MOCAP);
    assign o_status.done = (r_dcnt == 7'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_hx <= '0;
            r_hy <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_capture) begin
                r_qx <= i_qx; r_qy <= i_qy; r_qz <= i_qz; r_qw <= i_qw;
                r_px <= i_px; r_py <= i_py; r_vx <= i_vx; r_vy <= i_vy;
                r_lin <= '0;
                r_turn <= '0;
            end
            case (i_cmd.op)
                OP_QUAT: begin
                    r_i <= '0;
                    if (den < 0) begin
                        if (num >= 0) begin
                            r_x <= 36'(num); r_y <= -36'(den); r_z <= AngHalfPi;
                        end else begin
                            r_x <= -36'(num); r_y <= 36'(den); r_z <= -AngHalfPi;
                        end
                    end else begin
                        r_x <= 36'(den); r_y <= 36'(num); r_z <= '0;
                    end
                    r_flip <= (num == 0 && den == 0);
                end
                OP_VEC: begin
                    if (r_y > 0) begin
                        r_x <= r_x + ys; r_y <= r_y - xs;
                    end else begin
                        r_x <= r_x - ys; r_y <= r_y + xs;
                    end
                    r_z <= zn;
                    r_i <= r_i + 1'b1;
                    if (r_i == CW'(STEPS - 1)) begin
                        // degenerate vector keeps a zero heading
                        r_heading <= r_flip ? '0 : h_raw;
                        if (!o_rot_needed) begin
                            r_hx <= r_px;
                            r_hy <= r_py;
                        end
                    end
                end
                OP_LOAD: begin
                    r_i <= '0;
                    r_x <= CordicGain;
                    r_y <= '0;
                    if (zr > AngHalfPi) begin
                        r_z <= zr - AngPi; r_flip <= 1'b1;
                    end else if (zr < -AngHalfPi) begin
                        r_z <= zr + AngPi; r_flip <= 1'b1;
                    end else begin
                        r_z <= zr; r_flip <= 1'b0;
                    end
                end
                OP_ROT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - ang;
                    end else begin
                        r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + ang;
                    end
                    r_i <= r_i + 1'b1;
                end
                OP_POSE: begin
                    r_hx <= sat32(66'(r_px) + ((off_c + 66'sd536870912) >>> 30));
                    r_hy <= sat32(66'(py_adj) + ((off_s + 66'sd536870912) >>> 30));
                end
                OP_VEL: begin
                    r_vn <= 66'(r_vx) * 66'(cosv) + 66'(r_vy) * 66'(sinv);
                    r_wn <= 66'(r_vy) * 66'(cosv) - 66'(r_vx) * 66'(sinv);
                    r_dcnt <= 7'd66;
                end
                OP_DIV: begin
                    if (r_dcnt == 7'd66) begin
                        r_lin <= sat32((r_vn + 66'sd536870912) >>> 30);
                        r_neg <= r_wn[65];
                        r_mag <= 65'(r_wn[65] ? -r_wn : r_wn) + 65'(d_val >> 1);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_dcnt <= 7'd65;
                    end else if (r_dcnt != 7'd0) begin
                        if (rem_sh >= d_val) begin
                            r_rem <= rem_sh - d_val;
                            r_quo <= {r_quo[63:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[63:0], 1'b0};
                        end
                        r_mag <= {r_mag[63:0], 1'b0};
                        r_dcnt <= r_dcnt - 1'b1;
                    end else begin
                        r_turn <= r_neg ? sat32(-$signed({1'b0, r_quo}))
                                        : sat32($signed({1'b0, r_quo}));
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_lin = r_lin;
    assign o_turn = r_turn;
    assign o_heading = r_heading;
    assign o_hx = r_hx;
    assign o_hy = r_hy;

endmodule

[sv/handpoint_velocity_converter.sv]
// handpoint velocity converter top level: stream ports and config registers
// pose update: cordic vectoring, then cordic rotation and pose step (vectoring only for motion capture),
// velocity command: cordic rotation, then the 65-step divider; both share one cordic
// one transaction at a time; input reopens the cycle after the result is taken
// synchronous active-low reset clears pose, config to defaults
// depends on hvc_pkg, hvc_ctrl, hvc_dp
module handpoint_velocity_converter import hvc_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // quat_x,quat_y,quat_z,quat_w,pos_x,pos_y,vel_x,vel_y
    input  logic         s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,  // linear_speed,turn_rate,pose_heading,pose_x,pose_y
    output logic         m_axis_tuser,  // drive_valid
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [20:0]  i_cfg_data
);

    localparam int STEPS = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;

    logic [20:0] r_offset;
    logic [1:0] r_source;
    logic [3:0] r_index;
    logic r_ovalid, r_odrive;
    logic [143:0] r_odata;
    t_cmd cmd;
    t_status status;
    logic busy, load_out, rot_needed, start, kind;
    logic signed [31:0] lin, turn, hx, hy;
    logic signed [15:0] heading;

    assign s_axis_tready = !busy && !r_ovalid;
    assign start = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 21'd16384;
            r_source <= '0;
            r_index <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_OFFSET: if (i_cfg_data != '0) r_offset <= i_cfg_data;
                REG_SOURCE: r_source <= i_cfg_data[1:0];
                REG_INDEX:  r_index <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    hvc_ctrl #(.STEPS(STEPS)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_cmd(s_axis_tuser),
        .i_rot_needed(rot_needed), .i_status(status), .o_cmd(cmd),
        .o_busy(busy), .o_load_out(load_out), .o_kind(kind)
    );

    hvc_dp #(.STEPS(STEPS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_capture(start),
        .i_qx(s_axis_tdata[15:0]), .i_qy(s_axis_tdata[31:16]),
        .i_qz(s_axis_tdata[47:32]), .i_qw(s_axis_tdata[63:48]),
        .i_px(s_axis_tdata[95:64]), .i_py(s_axis_tdata[127:96]),
        .i_vx(s_axis_tdata[159:128]), .i_vy(s_axis_tdata[191:160]),
        .i_offset(r_offset), .i_source(r_source), .i_index(r_index),
        .o_status(status), .o_rot_needed(rot_needed),
        .o_lin(lin), .o_turn(turn), .o_heading(heading), .o_hx(hx), .o_hy(hy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_odrive <= kind;
            r_odata <= {hy, hx, heading, turn, lin};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_odrive;

endmodule

[tb/tb_handpoint_velocity_converter.sv]
// self-checking testbench for the handpoint velocity converter
// predicts pose and drive results in fixed point; depends on hvc_pkg and the dut
module tb_handpoint_velocity_converter;
    import hvc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Steps = 16;
    localparam longint TimeoutCycles = 2000000;

    typedef struct {
        logic        cmd;
        logic [15:0] qx, qy, qz, qw;
        logic [31:0] px, py, vx, vy;
    } t_item;

    typedef struct {
        logic        drive;
        logic [31:0] lin, turn;
        logic [15:0] hdg;
        logic [31:0] hx, hy;
    } t_result;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we = 0;
    logic [1:0]   i_cfg_addr = '0;
    logic [20:0]  i_cfg_data = '0;

    handpoint_velocity_converter #(.CORDIC_STEPS(Steps)) dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint  m_offset, m_source, m_robot;
    longint  m_heading, m_hx, m_hy;
    t_result expected_q[$];
    int      errors = 0;
    longint  cycles = 0;
    int      hold_off = 0;   // long receiver stall request
    int      burst_left = 0;

    longint atan_k[24] = '{421657428, 248918915, 131521918, 66762579, 33510843,
        16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};

    function automatic longint ashr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint yaw_of(longint x, longint y);
        longint z, t, h, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin t = x; x = y; y = -t; z = AngHalfPi; end
            else begin t = x; x = -y; y = t; z = -AngHalfPi; end
        end
        for (int i = 0; i < Steps; i++) begin
            xs = ashr(x, i); ys = ashr(y, i);
            if (y > 0) begin x = x + ys; y = y - xs; z += atan_k[i]; end
            else begin x = x - ys; y = y + xs; z -= atan_k[i]; end
        end
        h = ashr(z + 32768, 16);
        if (h > HeadingMax) h = HeadingMax;
        if (h < -HeadingMax) h = -HeadingMax;
        return h;
    endfunction

    task automatic heading_trig(input longint ang, output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit flip;
        z = ang * 65536; x = CordicGain; y = 0; flip = 0;
        if (z > AngHalfPi) begin z -= AngPi; flip = 1; end
        else if (z < -AngHalfPi) begin z += AngPi; flip = 1; end
        for (int i = 0; i < Steps; i++) begin
            xs = ashr(x, i); ys = ashr(y, i);
            if (z >= 0) begin x = x - ys; y = y + xs; z -= atan_k[i]; end
            else begin x = x + ys; y = y - xs; z += atan_k[i]; end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_result(input t_item it);
        t_result r;
        longint qx, qy, qz, qw, px, py, c, s, vx, vy, vn, wn, d, mag, q;
        r.drive = it.cmd; r.lin = 0; r.turn = 0;
        if (!it.cmd) begin
            qx = $signed(it.qx); qy = $signed(it.qy);
            qz = $signed(it.qz); qw = $signed(it.qw);
            px = $signed(it.px); py = $signed(it.py);
            m_heading = yaw_of((longint'(1) << 28) - 2 * (qy * qy + qz * qz),
                               2 * (qw * qz + qx * qy));
            if (m_source == SRC_MOCAP) begin
                m_hx = px; m_hy = py;
            end else begin
                if (m_source != SRC_SIM) py -= (m_robot - 2) * 65536;
                heading_trig(m_heading, c, s);
                m_hx = clamp32(px + rnd_shift(m_offset * c, 30));
                m_hy = clamp32(py + rnd_shift(m_offset * s, 30));
            end
        end else begin
            vx = $signed(it.vx); vy = $signed(it.vy);
            heading_trig(m_heading, c, s);
            vn = vx * c + vy * s;
            wn = vy * c - vx * s;
            r.lin = 32'(clamp32(rnd_shift(vn, 30)));
            d = m_offset * 16384;
            mag = wn < 0 ? -wn : wn;
            q = (mag + d / 2) / d;
            r.turn = 32'(clamp32(wn < 0 ? -q : q));
        end
        r.hdg = m_heading[15:0];
        r.hx = m_hx[31:0];
        r.hy = m_hy[31:0];
        expected_q.push_back(r);
    endtask

    // receiver: own stall pattern plus requested long hold-off
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
        if (cycles > TimeoutCycles) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected transaction tuser=%0b data=%h", $time,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if ({e.hy, e.hx, e.hdg, e.turn, e.lin} !== m_axis_tdata
                        || e.drive !== m_axis_tuser) begin
                    $display("%0t mismatch exp drive=%0b lin=%h turn=%h hdg=%h x=%h y=%h",
                             $time, e.drive, e.lin, e.turn, e.hdg, e.hx, e.hy);
                    $display("%0t          act drive=%0b lin=%h turn=%h hdg=%h x=%h y=%h",
                             $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                             m_axis_tdata[79:64], m_axis_tdata[111:80],
                             m_axis_tdata[143:112]);
                    errors++;
                end
            end
        end
    end

    // tvalid stays up between back-to-back items and drops only for gaps
    task automatic send_item(input t_item it, input bit bursty);
        if (bursty) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {it.vy, it.vx, it.py, it.px, it.qw, it.qz, it.qy, it.qx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_result(it);
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] a, input logic [20:0] v);
        drain();
        i_cfg_we <= 1; i_cfg_addr <= a; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (a == REG_OFFSET) begin
            if (v != 0) m_offset = v;
        end else if (a == REG_SOURCE) m_source = v[1:0];
        else if (a == REG_INDEX) m_robot = v[3:0];
    endtask

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(0, 5))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 400000)) - 200000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.cmd = $urandom_range(0, 1);
        it.qx = rand_quat(); it.qy = rand_quat(); it.qz = rand_quat(); it.qw = rand_quat();
        it.px = rand_word(); it.py = rand_word(); it.vx = rand_word(); it.vy = rand_word();
        return it;
    endfunction

    function automatic t_item pose_item(input logic [15:0] x, y, z, w);
        t_item it;
        it = rand_item();
        it.cmd = 0; it.qx = x; it.qy = y; it.qz = z; it.qw = w;
        return it;
    endfunction

    task automatic test_directed;
        t_item it;
        // identity, yaw +pi (negative axis), half turn about a tilted axis, quarter turns, extreme components
        send_item(pose_item(16'h0000, 16'h0000, 16'h0000, 16'h4000), 0);
        send_item(pose_item(16'h0000, 16'h0000, 16'h4000, 16'h0000), 0);
        send_item(pose_item(16'h0000, 16'h2D41, 16'h2D41, 16'h0000), 0);
        send_item(pose_item(16'h0000, 16'h0000, 16'h2D41, 16'h2D41), 0);
        send_item(pose_item(16'h0000, 16'h0000, 16'hD2BF, 16'h2D41), 0);
        send_item(pose_item(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF), 0);
        send_item(pose_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        for (int i = 0; i < 8; i++) begin
            it = rand_item();
            it.cmd = 1;
            it.vx = (i & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            it.vy = (i & 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            if (i >= 6) begin it.vx = 0; it.vy = i == 6 ? 32'hFFFF_FFFF : 32'h1; end
            send_item(it, 0);
        end
        it = pose_item(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        it.px = 32'h7FFF_FFFF; it.py = 32'h8000_0000;
        send_item(it, 0);
    endtask

    task automatic test_config;
        t_item it;
        logic [20:0] offs[5] = '{21'd1, 21'h10_0000, 21'h1F_FFFF, 21'd0, 21'd16384};
        foreach (offs[k]) begin
            write_reg(REG_OFFSET, offs[k]);
            for (int s = 0; s < 4; s++) begin
                write_reg(REG_SOURCE, 21'(s));
                write_reg(REG_INDEX, 21'($urandom_range(0, 15)));
                repeat (4) send_item(rand_item(), 1);
            end
        end
        write_reg(REG_INDEX, 21'd15);
        write_reg(2'd3, 21'h1F_FFFF);   // unknown register index
        repeat (4) send_item(rand_item(), 1);
        write_reg(REG_INDEX, 21'd0);
        repeat (4) send_item(rand_item(), 1);
    endtask

    task automatic test_backpressure;
        drain();
        hold_off = 300;
        repeat (10) send_item(rand_item(), 0);
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_OFFSET, ph == 0 ? 21'd1 : 21'($urandom_range(1, 1048576)));
            write_reg(REG_SOURCE, 21'($urandom_range(0, 3)));
            write_reg(REG_INDEX, 21'($urandom_range(0, 15)));
            for (int n = 0; n < 300; n++) send_item(rand_item(), n > 40);
        end
    endtask

    initial begin
        m_offset = 16384; m_source = 0; m_robot = 0;
        m_heading = 0; m_hx = 0; m_hy = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_config();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
